@@ hdl/aes_pkg.sv @@
package aes_pkg;

    // byte tables, entry 0 leftmost
    typedef logic [0:255][7:0] t_sbox_tab;

    // per-round control from the sequencer to the round unit
    typedef struct packed {
        logic first;   // initial key addition only
        logic last;    // final round, no column mixing
        logic dec;     // inverse cipher
    } t_rnd_ctl;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KLEN = 3'd4;
    localparam logic [2:0] REG_DIR  = 3'd5;

    // key length codes; any other code selects 256 bits
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam t_sbox_tab SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // inverse table, worked out at elaboration
    function automatic t_sbox_tab invert_tab(input t_sbox_tab f);
        t_sbox_tab t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[f[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam t_sbox_tab RSBOX = invert_tab(SBOX);

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [0:3][7:0] a, m9, m11, m13, m14;
        logic [7:0] x2, x4, x8;
        a = c;
        for (int i = 0; i < 4; i++) begin
            x2 = xt(a[i]);
            x4 = xt(x2);
            x8 = xt(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

endpackage

@@ hdl/aes_round.sv @@
module aes_round (
    input  aes_pkg::t_rnd_ctl i_ctl,
    input  logic [127:0]      i_state,
    input  logic [127:0]      i_key,
    output logic [127:0]      o_state
);

    logic [0:15][7:0] w_in;
    logic [0:15][7:0] w_ss;
    logic [0:3][31:0] w_ssk;
    logic [0:3][31:0] w_ss_col;
    logic [0:3][31:0] w_key_col;
    logic [0:3][31:0] w_mix;
    logic [1:0]       w_src;

    assign w_in      = i_state;
    assign w_ssk     = w_ss ^ i_key;
    assign w_ss_col  = w_ss;
    assign w_key_col = i_key;

    // byte substitution and row shift; byte r of column c comes from column c +/- r
    always_comb begin
        w_src = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_src = i_ctl.dec ? 2'(c - r) : 2'(c + r);
                w_ss[4 * c + r] = i_ctl.dec ? aes_pkg::RSBOX[w_in[{w_src, 2'(r)}]]
                                            : aes_pkg::SBOX[w_in[{w_src, 2'(r)}]];
            end
        end
    end

    // column mixing; the inverse mix is linear, so the key goes in before it
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_mix[c] = i_ctl.dec ? aes_pkg::inv_mix_col(w_ssk[c])
                                 : aes_pkg::mix_col(w_ss_col[c]) ^ w_key_col[c];
        end
    end

    always_comb begin
        priority if (i_ctl.first) begin
            o_state = i_state ^ i_key;
        end else if (i_ctl.last) begin
            o_state = w_ssk;
        end else begin
            o_state = w_mix;
        end
    end

endmodule

@@ hdl/aes_key_sched.sv @@
module aes_key_sched (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_key,
    input  logic [1:0]   i_klen,
    input  logic [3:0]   i_rd_addr,
    output logic         o_busy,
    output logic [127:0] o_rd_key
);

    logic [127:0]     mem [15];
    logic             r_busy;
    logic [5:0]       r_i;
    logic [2:0]       r_mod;
    logic [7:0]       r_rc;
    logic [7:0][31:0] r_win;     // index 0 is the newest word
    logic [2:0][31:0] r_acc;
    logic [127:0]     r_rd;

    logic [0:7][31:0] w_kw;
    logic [3:0]       w_nk;
    logic [5:0]       w_total;
    logic [31:0]      w_old;
    logic [31:0]      w_t;
    logic [31:0]      w_new;
    logic             w_rot;

    assign w_kw = i_key;

    always_comb begin
        unique case (i_klen)
            aes_pkg::KLEN_128: begin w_nk = 4'd4; w_old = r_win[3]; end
            aes_pkg::KLEN_192: begin w_nk = 4'd6; w_old = r_win[5]; end
            default:           begin w_nk = 4'd8; w_old = r_win[7]; end
        endcase
    end
    assign w_total = 6'(4 * (w_nk + 4'd7));

    // next schedule word from the previous one and the one nk back
    always_comb begin
        w_rot = 1'b0;
        w_t   = r_win[0];
        if (r_i < 6'(w_nk)) begin
            w_new = w_kw[r_i[2:0]];
        end else begin
            if (r_mod == 3'd0) begin
                w_rot = 1'b1;
                w_t   = aes_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rc, 24'd0};
            end else if (w_nk == 4'd8 && r_mod == 3'd4) begin
                w_t = aes_pkg::sub_word(r_win[0]);
            end
            w_new = w_old ^ w_t;
        end
    end

    // sequencer: one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
            r_mod  <= '0;
            r_rc   <= 8'h01;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_mod  <= '0;
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_i   <= r_i + 6'd1;
            r_mod <= (r_mod == 3'(w_nk - 4'd1)) ? 3'd0 : r_mod + 3'd1;
            if (w_rot) begin
                r_rc <= aes_pkg::xt(r_rc);
            end
            if (r_i == w_total - 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // word window and row assembly
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_win <= {r_win[6:0], w_new};
            if (r_i[1:0] != 2'd3) begin
                r_acc[r_i[1:0]] <= w_new;
            end
        end
    end

    // round key store, forward order: one row written, one row read
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start && r_i[1:0] == 2'd3) begin
            mem[r_i[5:2]] <= {r_acc[0], r_acc[1], r_acc[2], w_new};
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_busy   = r_busy;
    assign o_rd_key = r_rd;

endmodule

@@ hdl/aes_block_cipher_ecb_unit.sv @@
// Channel  Direction  Ports                      Beat contents
// s_axis   in         i_s_axis_t*, o_s_axis_tready  one 128-bit block
// m_axis   out        o_m_axis_t*, i_m_axis_tready  one 128-bit result
// cfg      in         i_cfg_*, o_cfg_ready          register index and 64-bit data
//
// A block passes the round unit once for the initial key addition and once for
// each of 10, 12 or 14 rounds for 128, 192 or 256 bit keys, one round per cycle
// while no held result stalls the final round; the next block is taken in idle.
// After reset or any write to register index 0 to 5 the key schedule runs once,
// producing 44, 52 or 60 words, one word per cycle; no block is accepted meanwhile.
// Reset is synchronous, active low, and leaves the schedule to be rebuilt.
// A result held on m_axis stalls the final round until the slot frees.
module aes_block_cipher_ecb_unit #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // [63:0] block_hi, [127:64] block_lo
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // [63:0] result_hi, [127:64] result_lo
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state         r_state;
    logic [63:0]    r_kw0, r_kw1, r_kw2, r_kw3;
    logic [1:0]     r_klen;
    logic           r_dir;
    logic           r_stale;
    logic [3:0]     r_rnd;
    logic [127:0]   r_blk;
    logic           r_ovalid;
    logic [127:0]   r_out;

    logic           w_cfg_wr;
    logic           w_key_busy;
    logic           w_start;
    logic           w_in_acc;
    logic           w_out_free;
    logic           w_last;
    logic [3:0]     w_rounds;
    logic [3:0]     w_next_rnd;
    logic [3:0]     w_rd_addr;
    logic [127:0]   w_rd_key;
    logic [0:3][31:0] w_rnd_key;
    logic [127:0]   w_rnd_out;
    aes_pkg::t_rnd_ctl w_ctl;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_wr        = i_cfg_valid;
    assign w_start         = r_stale && !w_key_busy && r_state == S_IDLE;
    assign o_s_axis_tready = r_state == S_IDLE && !r_stale && !w_key_busy;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    always_comb begin
        unique case (r_klen)
            aes_pkg::KLEN_128: w_rounds = 4'd10;
            aes_pkg::KLEN_192: w_rounds = 4'd12;
            default:           w_rounds = 4'd14;
        endcase
    end

    assign w_last     = r_rnd == w_rounds;
    assign w_ctl      = '{first: r_rnd == 4'd0, last: w_last, dec: r_dir};
    // key row for the round after this one; a stalled last round keeps its row,
    // a finishing block fetches row 0 for the next one
    assign w_next_rnd = (r_state == S_IDLE || (w_last && w_out_free)) ? 4'd0 :
                        (w_last ? r_rnd : r_rnd + 4'd1);
    assign w_rd_addr  = r_dir ? w_rounds - w_next_rnd : w_next_rnd;

    aes_key_sched u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_key     ({r_kw0, r_kw1, r_kw2, r_kw3}),
        .i_klen    (r_klen),
        .i_rd_addr (w_rd_addr),
        .o_busy    (w_key_busy),
        .o_rd_key  (w_rd_key)
    );

    // round key words past the store depth read as zero
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_rnd_key[j] = (4 * int'(r_rnd) + j < ROUND_KEY_WORDS) ?
                           w_rd_key[127 - 32 * j -: 32] : 32'd0;
        end
    end

    aes_round u_round (
        .i_ctl   (w_ctl),
        .i_state (r_blk),
        .i_key   (w_rnd_key),
        .o_state (w_rnd_out)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw0   <= '0;
            r_kw1   <= '0;
            r_kw2   <= '0;
            r_kw3   <= '0;
            r_klen  <= '0;
            r_dir   <= 1'b0;
            r_stale <= 1'b1;
        end else begin
            if (w_start) begin
                r_stale <= 1'b0;
            end
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    aes_pkg::REG_KEY0: begin r_kw0  <= i_cfg_data;      r_stale <= 1'b1; end
                    aes_pkg::REG_KEY1: begin r_kw1  <= i_cfg_data;      r_stale <= 1'b1; end
                    aes_pkg::REG_KEY2: begin r_kw2  <= i_cfg_data;      r_stale <= 1'b1; end
                    aes_pkg::REG_KEY3: begin r_kw3  <= i_cfg_data;      r_stale <= 1'b1; end
                    aes_pkg::REG_KLEN: begin r_klen <= i_cfg_data[1:0]; r_stale <= 1'b1; end
                    aes_pkg::REG_DIR:  begin r_dir  <= i_cfg_data[0];   r_stale <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    // round sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rnd    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_RUN && w_last && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_blk   <= {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
                        r_rnd   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!w_last) begin
                        r_blk <= w_rnd_out;
                        r_rnd <= r_rnd + 4'd1;
                    end else if (w_out_free) begin
                        r_out    <= w_rnd_out;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    // no block starts on a schedule that is stale or still being built
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !w_key_busy && !r_stale)
        else $error("block accepted during key expansion");

    // the round counter never passes the round count
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_rnd <= w_rounds)
        else $error("round counter out of range");

    // leaving the round loop always presents a result
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && w_last && w_out_free |=> r_ovalid && r_state == S_IDLE)
        else $error("result not presented");

    // no expansion starts while a block is in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> r_state == S_IDLE)
        else $error("key expansion started mid-block");

endmodule
